// File: design/bsv_pkg.sv
package bsv_pkg;

    localparam int DEF_MAX_PROGRAM = 64;
    localparam int DEF_REG_COUNT   = 11;
    localparam int DEF_STACK_BYTES = 512;

    localparam int LEN_W        = 7;
    localparam int CTX_BYTES    = 64;
    localparam int ACCESS_BYTES = 8;

    localparam logic [7:0] SRC_IMM = 8'd255;
    localparam logic [7:0] SRC_MAP = 8'd254;

    typedef enum logic [2:0] {
        MODE_MOV,
        MODE_ADD,
        MODE_SUB,
        MODE_LOAD,
        MODE_STORE,
        MODE_JEQ,
        MODE_JGT,
        MODE_EXIT
    } mode_t;

    typedef enum logic [2:0] {
        KIND_UNINIT,
        KIND_SCALAR,
        KIND_CTX,
        KIND_MAP,
        KIND_STACK
    } kind_t;

    typedef enum logic [3:0] {
        ST_OK,
        ST_ACCEPT,
        ST_BADREG,
        ST_PTRARITH,
        ST_BOUNDS,
        ST_UNINIT_STACK,
        ST_BADPTR,
        ST_LEAK,
        ST_JUMP,
        ST_EXITTYPE,
        ST_NOEXIT,
        ST_SKIPPED
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [31:0] mb;
        logic [63:0] po;
    } rf_entry_t;

endpackage

// File: design/bytecode_safety_verifier.sv
// Instruction-stream safety checker.
// Input channel (in_valid/in_ready): one instruction per beat; start_req marks the
// first instruction of a program and clears registers, stack map and position.
// Output channel (out_valid/out_ready): one status beat per instruction, in order;
// verdict_done marks the beat that ends the program. Later beats of that program
// return skipped until the next start_req.
// Configuration: cfg_wr_en writes cfg_wr_data into the program length; write only
// while no beat is in flight.
// Stages: an accepted instruction is registered into the execute stage, and its status
// is registered from there; a load through the stack pointer also waits for the stack map read.
// Throughput: one instruction per cycle while the receiver takes each status beat; a
// stack load waits for the stack map read, which depends on the register-file read.
// Register state lives in a two-read, one-write register file with a forwarding
// path for the write just retired; the stack map is two 8-bit-wide banks so an
// unaligned 8-byte access touches one row in each bank.
// Reset clears valid bits of registers and stack rows at once; no clearing pass.
// A stalled receiver holds the status beat; one more instruction may enter and
// then waits until the beat is taken.
module bytecode_safety_verifier
    import bsv_pkg::*;
#(
    parameter int MAX_PROGRAM = DEF_MAX_PROGRAM,
    parameter int REG_COUNT   = DEF_REG_COUNT,
    parameter int STACK_BYTES = DEF_STACK_BYTES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               start_req,
    input  logic [2:0]         mode,
    input  logic [7:0]         dest_index,
    input  logic [7:0]         source_index,
    input  logic signed [15:0] displacement,
    input  logic signed [63:0] immediate,
    input  logic [31:0]        map_bytes,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         status,
    output logic               verdict_done,
    input  logic               cfg_wr_en,
    input  logic [LEN_W-1:0]   cfg_wr_data
);

    localparam int IW    = $clog2(REG_COUNT);
    localparam int PW    = $clog2(MAX_PROGRAM + 1);
    localparam int CW    = (PW > LEN_W) ? PW : LEN_W;
    localparam int JW    = CW + 18;
    localparam int SAW   = $clog2(STACK_BYTES);
    localparam int ROWS  = STACK_BYTES / ACCESS_BYTES;
    localparam int HROWS = ROWS / 2;
    localparam int RW    = $clog2(ROWS);
    localparam int BW    = RW - 1;

    localparam logic [IW-1:0]     CTX_IDX = IW'(1);
    localparam logic [IW-1:0]     FP_IDX  = IW'(REG_COUNT - 1);
    localparam logic [7:0]        FP_NUM  = 8'(REG_COUNT - 1);
    localparam logic signed [65:0] STK_LO = 66'(-STACK_BYTES);
    localparam logic signed [65:0] STK_HI = 66'(-ACCESS_BYTES);
    localparam logic signed [65:0] ACC_X  = 66'(ACCESS_BYTES);

    function automatic rf_entry_t rst_entry(input logic [IW-1:0] a);
        rf_entry_t e;
        e      = '0;
        e.kind = (a == CTX_IDX) ? KIND_CTX : (a == FP_IDX) ? KIND_STACK : KIND_UNINIT;
        return e;
    endfunction

    logic [LEN_W-1:0]   len_reg;

    logic               ex_valid_reg;
    logic               ex_start_reg;
    mode_t              ex_mode_reg;
    logic [7:0]         ex_dest_reg;
    logic [7:0]         ex_src_reg;
    logic [IW-1:0]      ex_ra_reg;
    logic [IW-1:0]      ex_sa_reg;
    logic signed [15:0] ex_disp_reg;
    logic [63:0]        ex_imm_reg;
    logic [31:0]        ex_mb_reg;
    logic               stk_pend_reg;

    rf_entry_t          rf_mem [REG_COUNT];
    rf_entry_t          rf_d_reg;
    rf_entry_t          rf_s_reg;
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [REG_COUNT-1:0] rf_valid_next;
    logic               fwd_en_reg;
    logic [IW-1:0]      fwd_addr_reg;
    rf_entry_t          fwd_data_reg;

    logic [PW-1:0]      pos_reg;
    logic [PW-1:0]      pos_next;
    logic               fin_reg;
    logic               fin_next;

    logic [7:0]         stk_even_mem [HROWS];
    logic [7:0]         stk_odd_mem  [HROWS];
    logic [7:0]         even_reg;
    logic [7:0]         odd_reg;
    logic [ROWS-1:0]    row_valid_reg;
    logic [ROWS-1:0]    row_valid_next;

    logic               out_valid_reg;
    status_t            status_reg;
    logic               verdict_reg;

    logic               acc;
    logic               ex_done;
    logic [IW-1:0]      ra_d;
    logic [IW-1:0]      ra_s;

    rf_entry_t          ent_d;
    rf_entry_t          ent_s;
    rf_entry_t          ptr;
    rf_entry_t          wr_data;
    logic               wr_want;
    logic               wr_en;
    logic               d_in;
    logic               s_in;
    logic               rd_d;
    logic               rd_s;
    logic               is_add;
    logic [63:0]        val;
    logic [63:0]        lo_res;
    logic [63:0]        hi_res;
    logic [63:0]        po_res;
    logic               map_bad;
    logic [63:0]        off;
    logic signed [65:0] off_x;
    logic signed [65:0] lim_x;
    logic [65:0]        stk_b_full;
    logic [SAW-1:0]     stk_b;
    logic [RW-1:0]      r0;
    logic [RW:0]        r0p;
    logic [2:0]         sh;
    logic [7:0]         mask0;
    logic [7:0]         mask1;
    logic [7:0]         mask_e;
    logic [7:0]         mask_o;
    logic [BW-1:0]      even_addr;
    logic [BW-1:0]      odd_addr;
    logic [RW-1:0]      even_row;
    logic [RW-1:0]      odd_row;
    logic [7:0]         data_e;
    logic [7:0]         data_o;
    logic [7:0]         ben_e;
    logic [7:0]         ben_o;
    logic               oob_heap;
    logic               oob_stk;
    logic               uninit;
    logic               need_stack;
    logic               stk_wr;
    logic signed [JW-1:0] tgt;
    logic signed [JW-1:0] len_x;
    logic               fin_e;
    logic [PW-1:0]      pos_e;
    logic [PW-1:0]      pos_inc;
    logic               run;
    logic               len_bad;
    status_t            st_exec;
    status_t            st_final;

    assign acc      = in_valid && in_ready;
    assign in_ready = !ex_valid_reg || ex_done;
    assign ex_done  = ex_valid_reg && !(need_stack && !stk_pend_reg)
                      && (!out_valid_reg || out_ready);

    assign ra_d = (mode_t'(mode) == MODE_EXIT) ? '0 : dest_index[IW-1:0];
    assign ra_s = source_index[IW-1:0];

    always_comb
    begin
        if (ex_start_reg || !rf_valid_reg[ex_ra_reg])
            ent_d = rst_entry(ex_ra_reg);
        else if (fwd_en_reg && fwd_addr_reg == ex_ra_reg)
            ent_d = fwd_data_reg;
        else
            ent_d = rf_d_reg;

        if (ex_start_reg || !rf_valid_reg[ex_sa_reg])
            ent_s = rst_entry(ex_sa_reg);
        else if (fwd_en_reg && fwd_addr_reg == ex_sa_reg)
            ent_s = fwd_data_reg;
        else
            ent_s = rf_s_reg;
    end

    assign d_in   = 32'(ex_dest_reg) < REG_COUNT;
    assign s_in   = 32'(ex_src_reg) < REG_COUNT;
    assign rd_d   = d_in && ent_d.kind != KIND_UNINIT;
    assign rd_s   = s_in && ent_s.kind != KIND_UNINIT;
    assign is_add = ex_mode_reg == MODE_ADD;

    assign val     = s_in ? ent_s.lo : ex_imm_reg;
    assign lo_res  = is_add ? ent_d.lo + val : ent_d.lo - val;
    assign hi_res  = is_add ? ent_d.hi + val : ent_d.hi - val;
    assign po_res  = is_add ? ent_d.po + val : ent_d.po - val;
    assign map_bad = po_res[63] || po_res >= 64'(ent_d.mb);

    assign ptr   = (ex_mode_reg == MODE_STORE) ? ent_d : ent_s;
    assign off   = ptr.po + 64'(ex_disp_reg);
    assign off_x = 66'(signed'(off));
    assign lim_x = (ptr.kind == KIND_MAP) ? 66'(ptr.mb) : 66'(CTX_BYTES);
    assign oob_heap = off_x < 0 || off_x > lim_x - ACC_X;
    assign oob_stk  = off_x < STK_LO || off_x > STK_HI;

    assign stk_b_full = off_x + 66'(STACK_BYTES);
    assign stk_b      = stk_b_full[SAW-1:0];
    assign r0         = stk_b[SAW-1:3];
    assign sh         = stk_b[2:0];
    assign r0p        = {1'b0, r0} + (RW+1)'(1);
    assign even_addr  = r0p[RW-1:1];
    assign odd_addr   = r0[RW-1:1];
    assign even_row   = {even_addr, 1'b0};
    assign odd_row    = {odd_addr, 1'b1};
    assign mask0      = 8'hFF << sh;
    assign mask1      = ~mask0;
    assign mask_e     = r0[0] ? mask1 : mask0;
    assign mask_o     = r0[0] ? mask0 : mask1;
    assign data_e     = (!ex_start_reg && row_valid_reg[even_row]) ? even_reg : 8'h00;
    assign data_o     = (!ex_start_reg && row_valid_reg[odd_row]) ? odd_reg : 8'h00;
    assign uninit     = |(mask_e & ~data_e) || |(mask_o & ~data_o);
    assign ben_e      = (!ex_start_reg && row_valid_reg[even_row]) ? mask_e : 8'hFF;
    assign ben_o      = (!ex_start_reg && row_valid_reg[odd_row]) ? mask_o : 8'hFF;

    assign len_x = JW'(len_reg);
    assign tgt   = JW'(pos_e) + JW'(1) + JW'(ex_disp_reg);

    always_comb
    begin
        st_exec    = ST_OK;
        wr_want    = 1'b0;
        wr_data    = ent_d;
        need_stack = 1'b0;
        stk_wr     = 1'b0;
        case (ex_mode_reg)
            MODE_MOV, MODE_ADD, MODE_SUB:
            begin
                if (!d_in || ex_dest_reg == FP_NUM)
                    st_exec = ST_BADREG;
                else if (ex_mode_reg == MODE_MOV)
                begin
                    if (s_in)
                    begin
                        if (!rd_s)
                            st_exec = ST_BADREG;
                        else
                        begin
                            wr_data = ent_s;
                            wr_want = 1'b1;
                        end
                    end
                    else if (ex_src_reg == SRC_IMM)
                    begin
                        wr_data.kind = KIND_SCALAR;
                        wr_data.lo   = ex_imm_reg;
                        wr_data.hi   = ex_imm_reg;
                        wr_data.po   = '0;
                        wr_want      = 1'b1;
                    end
                    else if (ex_src_reg == SRC_MAP)
                    begin
                        wr_data.kind = KIND_MAP;
                        wr_data.mb   = ex_mb_reg;
                        wr_data.po   = ex_imm_reg;
                        wr_data.lo   = '0;
                        wr_data.hi   = '0;
                        wr_want      = 1'b1;
                    end
                    else
                        st_exec = ST_BADREG;
                end
                else if (ent_d.kind == KIND_UNINIT)
                    st_exec = ST_BADREG;
                else if (s_in && !rd_s)
                    st_exec = ST_BADREG;
                else if (!s_in && ex_src_reg != SRC_IMM)
                    st_exec = ST_BADREG;
                else if (s_in && ent_s.kind != KIND_SCALAR)
                    st_exec = ST_PTRARITH;
                else if (ent_d.kind == KIND_SCALAR)
                begin
                    wr_data.lo = lo_res;
                    wr_data.hi = hi_res;
                    wr_want    = 1'b1;
                end
                else if (ent_d.kind == KIND_MAP && map_bad)
                    st_exec = ST_BOUNDS;
                else
                begin
                    wr_data.po = po_res;
                    wr_want    = 1'b1;
                end
            end
            MODE_LOAD:
            begin
                if (ex_dest_reg >= FP_NUM || !rd_s)
                    st_exec = ST_BADREG;
                else if (ent_s.kind == KIND_MAP || ent_s.kind == KIND_CTX)
                begin
                    if (oob_heap)
                        st_exec = ST_BOUNDS;
                end
                else if (ent_s.kind == KIND_STACK)
                begin
                    if (oob_stk)
                        st_exec = ST_BOUNDS;
                    else
                    begin
                        need_stack = 1'b1;
                        if (uninit)
                            st_exec = ST_UNINIT_STACK;
                    end
                end
                else
                    st_exec = ST_BADPTR;
                wr_data.kind = KIND_SCALAR;
                wr_data.lo   = '0;
                wr_data.hi   = '0;
                wr_data.po   = '0;
                wr_want      = 1'b1;
            end
            MODE_STORE:
            begin
                if (!rd_d || !rd_s)
                    st_exec = ST_BADREG;
                else if (ent_d.kind == KIND_MAP || ent_d.kind == KIND_CTX)
                begin
                    if (oob_heap)
                        st_exec = ST_BOUNDS;
                    else if (ent_s.kind != KIND_SCALAR)
                        st_exec = ST_LEAK;
                end
                else if (ent_d.kind == KIND_STACK)
                begin
                    if (oob_stk)
                        st_exec = ST_BOUNDS;
                    else
                        stk_wr = 1'b1;
                end
                else
                    st_exec = ST_BADPTR;
            end
            MODE_JEQ, MODE_JGT:
            begin
                if (!rd_d)
                    st_exec = ST_BADREG;
                else if (tgt < 0 || tgt >= len_x)
                    st_exec = ST_JUMP;
            end
            MODE_EXIT:
            begin
                if (ent_d.kind == KIND_UNINIT)
                    st_exec = ST_BADREG;
                else if (ent_d.kind != KIND_SCALAR)
                    st_exec = ST_EXITTYPE;
                else
                    st_exec = ST_ACCEPT;
            end
            default:
                st_exec = ST_BADREG;
        endcase
    end

    assign fin_e   = !ex_start_reg && fin_reg;
    assign pos_e   = ex_start_reg ? '0 : pos_reg;
    assign pos_inc = pos_e + PW'(1);
    assign len_bad = len_reg == '0 || 32'(len_reg) > MAX_PROGRAM;

    always_comb
    begin
        run      = 1'b0;
        st_final = st_exec;
        if (fin_e)
            st_final = ST_SKIPPED;
        else if (len_bad)
            st_final = ST_JUMP;
        else if (CW'(pos_e) >= CW'(len_reg))
            st_final = ST_NOEXIT;
        else
        begin
            run = 1'b1;
            if (st_exec == ST_OK && CW'(pos_inc) >= CW'(len_reg))
                st_final = ST_NOEXIT;
        end
    end

    assign wr_en = run && wr_want && st_exec == ST_OK;

    always_comb
    begin
        fin_next       = fin_reg;
        pos_next       = pos_reg;
        rf_valid_next  = ex_start_reg ? '0 : rf_valid_reg;
        row_valid_next = ex_start_reg ? '0 : row_valid_reg;
        if (!fin_e)
        begin
            fin_next = st_final != ST_OK;
            pos_next = (run && st_exec == ST_OK) ? pos_inc : pos_e;
        end
        if (wr_en)
            rf_valid_next[ex_ra_reg] = 1'b1;
        if (run && stk_wr && st_exec == ST_OK)
        begin
            if (mask_e != '0)
                row_valid_next[even_row] = 1'b1;
            if (mask_o != '0)
                row_valid_next[odd_row] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LEN_W'(1);
            ex_valid_reg  <= 1'b0;
            stk_pend_reg  <= 1'b0;
            rf_valid_reg  <= '0;
            row_valid_reg <= '0;
            fwd_en_reg    <= 1'b0;
            pos_reg       <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                len_reg <= cfg_wr_data;
            if (acc)
                ex_valid_reg <= 1'b1;
            else if (ex_done)
                ex_valid_reg <= 1'b0;
            if (ex_done)
                stk_pend_reg <= 1'b0;
            else if (ex_valid_reg && need_stack)
                stk_pend_reg <= 1'b1;
            if (ex_done)
            begin
                rf_valid_reg  <= rf_valid_next;
                row_valid_reg <= row_valid_next;
                pos_reg       <= pos_next;
                fin_reg       <= fin_next;
                if (wr_en)
                    fwd_en_reg <= 1'b1;
            end
            if (ex_done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            ex_start_reg <= start_req;
            ex_mode_reg  <= mode_t'(mode);
            ex_dest_reg  <= dest_index;
            ex_src_reg   <= source_index;
            ex_ra_reg    <= ra_d;
            ex_sa_reg    <= ra_s;
            ex_disp_reg  <= displacement;
            ex_imm_reg   <= immediate;
            ex_mb_reg    <= map_bytes;
            rf_d_reg     <= rf_mem[ra_d];
            rf_s_reg     <= rf_mem[ra_s];
        end
        if (ex_done && wr_en)
        begin
            rf_mem[ex_ra_reg] <= wr_data;
            fwd_addr_reg      <= ex_ra_reg;
            fwd_data_reg      <= wr_data;
        end
        if (ex_done)
        begin
            status_reg  <= st_final;
            verdict_reg <= !fin_e && st_final != ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        even_reg <= stk_even_mem[even_addr];
        odd_reg  <= stk_odd_mem[odd_addr];
        if (ex_done && run && stk_wr && st_exec == ST_OK)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (ben_e[i])
                    stk_even_mem[even_addr][i] <= mask_e[i];
                if (ben_o[i])
                    stk_odd_mem[odd_addr][i] <= mask_o[i];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign verdict_done = verdict_reg;

endmodule

// File: design/bsv_checker.sv
module bsv_checker
    import bsv_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] status,
    input logic       verdict_done
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(verdict_done))
        else $error("status beat changed while stalled");

    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> verdict_done == (status != 4'(ST_OK) && status != 4'(ST_SKIPPED)))
        else $error("verdict flag disagrees with status");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("status beat present after reset");

endmodule

bind bytecode_safety_verifier bsv_checker u_bsv_checker (.*);
